@@ hdl/tdp_pkg.sv @@
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants for the trial-division prime test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

    // Width of the candidate and of all arithmetic on it
    localparam int VALUE_BITS = 32;

    // Bit counter of the divider, able to hold VALUE_BITS itself
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;

    // Small constants used by the sequencer
    localparam value_t VAL_TWO   = value_t'(2);
    localparam value_t VAL_THREE = value_t'(3);
    localparam value_t VAL_FOUR  = value_t'(4);
    localparam value_t VAL_FIVE  = value_t'(5);
    localparam value_t VAL_ZERO  = value_t'(0);

    // Result of one division
    typedef struct packed {
        value_t quotient;
        value_t remainder;
    } div_res_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RESULT
    } state_t;

endpackage

@@ hdl/tdp_div.sv @@
// ----------------------------------------------------------------------------
// tdp_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tdp_pkg::value_t   dividend,
    input  tdp_pkg::value_t   divisor,
    output logic              done,
    output tdp_pkg::div_res_t res
);
    import tdp_pkg::*;

    value_t                rem_reg;
    value_t                quo_reg;
    value_t                dsr_reg;
    count_t                cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;
    logic                  ge;

    // One restoring step: shift in next dividend bit, trial subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = (shifted >= {1'b0, dsr_reg});
    end

    // Control: count VALUE_BITS steps, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == count_t'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count_t'(VALUE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - count_t'(1);
                if (cnt_reg == count_t'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: quotient register doubles as dividend shifter
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= VAL_ZERO;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
            quo_reg <= {quo_reg[VALUE_BITS-2:0], ge};
        end
    end

    assign done          = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

@@ hdl/trial_division_prime_test.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Classifies one unsigned candidate per transfer as prime or not prime by
// trial division with divisors 2, 3, then 6k-1 and 6k+1.
//
//   Channel   | Handshake              | Payload
//   ----------+------------------------+-------------------------------
//   cand      | cand_valid/cand_ready  | candidate
//   res       | res_valid/res_ready    | number, is_prime
//
// One candidate at a time: cand_ready is high only while idle.
// Each trial divisor takes one full pass of the shared bit-serial
// divider; about sqrt(n)/3 divisors are tried for a prime n.
// Candidates below four skip the divider. The result is held on res until
// taken; rst_n clears only the sequencer and the divider's control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trial_division_prime_test (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cand_valid,
    output logic            cand_ready,
    input  tdp_pkg::value_t candidate,
    output logic            res_valid,
    input  logic            res_ready,
    output tdp_pkg::value_t number,
    output logic            is_prime
);
    import tdp_pkg::*;

    state_t   state_reg;
    state_t   state_next;

    value_t   n_reg;
    value_t   d_reg;
    logic     step4_reg;
    logic     prime_reg;

    logic     div_start;
    logic     div_done;
    div_res_t div_res;

    logic     cand_xfer;
    logic     res_xfer;
    logic     d_past_root;
    logic     d_divides;

    assign cand_xfer   = cand_valid & cand_ready;
    assign res_xfer    = res_valid & res_ready;
    assign d_past_root = (d_reg > div_res.quotient);
    assign d_divides   = (div_res.remainder == VAL_ZERO);

    // Shared divider
    tdp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .res      (div_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cand_xfer)
                    state_next = (candidate < VAL_FOUR) ? ST_RESULT : ST_DIV_START;
            end
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (d_past_root || d_divides) ? ST_RESULT : ST_DIV_START;
            end
            ST_RESULT:
            begin
                if (res_xfer)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cand_ready = 1'b0;
        res_valid  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:      cand_ready = 1'b1;
            ST_DIV_START: div_start  = 1'b1;
            ST_DIV_WAIT:  ;
            ST_RESULT:    res_valid  = 1'b1;
            default:      ;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Candidate, trial divisor and verdict
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cand_xfer)
        begin
            n_reg     <= candidate;
            d_reg     <= VAL_TWO;
            step4_reg <= 1'b0;
            prime_reg <= (candidate >= VAL_TWO);
        end
        else if (state_reg == ST_DIV_WAIT && div_done)
        begin
            if (d_past_root)
                prime_reg <= 1'b1;
            else if (d_divides)
                prime_reg <= 1'b0;
            else if (d_reg == VAL_TWO)
                d_reg <= VAL_THREE;
            else if (d_reg == VAL_THREE)
            begin
                d_reg     <= VAL_FIVE;
                step4_reg <= 1'b0;
            end
            else
            begin
                // alternate +2 / +4 to walk 6k-1, 6k+1
                d_reg     <= d_reg + (step4_reg ? VAL_FOUR : VAL_TWO);
                step4_reg <= ~step4_reg;
            end
        end
    end

    assign number   = n_reg;
    assign is_prime = prime_reg;

endmodule

@@ tb/tb_trial_division_prime_test.sv @@
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test
// Self-checking bench for the trial-division prime test block. A queue of
// candidates feeds a clocked driver; each accepted candidate gets its verdict
// worked out by an independent trial-division predictor. A clocked monitor
// compares every result transfer against the oldest pending verdict. Random
// idle bursts are applied on both channels, with a quiet tail at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

    localparam int RANDOM_ITEMS = 80;
    localparam int QUIET_TAIL   = 20;      // last items run with no idling
    localparam int STALL_LIMIT  = 400000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        tdp_pkg::value_t value;
        bit              drain_first;  // hold off until all verdicts are back
    } cand_item_t;

    typedef struct {
        tdp_pkg::value_t number;
        logic            is_prime;
    } verdict_t;

    logic            clk;
    logic            rst_n;
    logic            cand_valid;
    logic            cand_ready;
    tdp_pkg::value_t candidate;
    logic            res_valid;
    logic            res_ready;
    tdp_pkg::value_t number;
    logic            is_prime;

    cand_item_t candidate_backlog[$];
    verdict_t   pending_verdicts[$];

    int  mismatches;
    int  idle_cycles;
    int  send_gap;
    int  take_stall;

    trial_division_prime_test uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .candidate  (candidate),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .number     (number),
        .is_prime   (is_prime)
    );

    // Plain trial division over all odd divisors up to the square root
    function automatic logic trial_prime(tdp_pkg::value_t n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 3; d * d <= n; d += 2)
        begin
            if ((n % d) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void add_candidate(tdp_pkg::value_t v, bit drain);
        cand_item_t it;
        it.value       = v;
        it.drain_first = drain;
        candidate_backlog.push_back(it);
    endfunction

    // No idling once only the tail of the backlog is left
    function automatic bit quiet_phase();
        return (candidate_backlog.size() < QUIET_TAIL);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Candidate driver
    always @(posedge clk or negedge rst_n)
    begin
        cand_item_t      it;
        verdict_t        v;
        logic            valid_n;
        tdp_pkg::value_t cand_n;
        if (!rst_n)
        begin
            cand_valid <= 1'b0;
            candidate  <= '0;
            send_gap   <= 0;
        end
        else
        begin
            valid_n = cand_valid;
            cand_n  = candidate;
            // transfer taken: record the verdict it must produce
            if (cand_valid && cand_ready)
            begin
                v.number   = candidate;
                v.is_prime = trial_prime(candidate);
                pending_verdicts.push_back(v);
                valid_n = 1'b0;
            end
            if (!valid_n)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (candidate_backlog.size() != 0 &&
                         !(candidate_backlog[0].drain_first && pending_verdicts.size() != 0))
                begin
                    if (!quiet_phase() && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 19) - 1;
                    else
                    begin
                        it      = candidate_backlog.pop_front();
                        valid_n = 1'b1;
                        cand_n  = it.value;
                    end
                end
            end
            cand_valid <= valid_n;
            candidate  <= cand_n;
        end
    end

    // Result monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            take_stall <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with none pending: number=%0d is_prime=%0b",
                                 $realtime, number, is_prime);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    v = pending_verdicts.pop_front();
                    if (number !== v.number || is_prime !== v.is_prime)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch: expected number=%0d is_prime=%0b,",
                                      " got number=%0d is_prime=%0b"},
                                     $realtime, v.number, v.is_prime, number, is_prime);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // bursts of stall, none in the quiet tail
            if (take_stall > 0)
            begin
                take_stall <= take_stall - 1;
                res_ready  <= 1'b0;
            end
            else if (!quiet_phase() && $urandom_range(0, 7) == 0)
            begin
                take_stall <= $urandom_range(1, 19) - 1;
                res_ready  <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Watchdog: cycles since the last transfer on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((cand_valid && cand_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus, reset and end of run
    initial
    begin
        tdp_pkg::value_t x;
        int unsigned     kind;
        int unsigned     factor_list[8] = '{101, 103, 107, 127, 131, 193, 241, 251};

        rst_n = 1'b0;

        // directed: edges, tiny values, squares of primes, large values
        add_candidate(32'd0, 1'b0);
        add_candidate(32'd1, 1'b0);
        add_candidate(32'd2, 1'b0);
        add_candidate(32'd3, 1'b0);
        add_candidate(32'd4, 1'b0);
        add_candidate(32'd5, 1'b0);
        add_candidate(32'd6, 1'b0);
        add_candidate(32'd7, 1'b0);
        add_candidate(32'd9, 1'b0);
        add_candidate(32'd25, 1'b0);
        add_candidate(32'd49, 1'b0);
        add_candidate(32'd121, 1'b0);
        add_candidate(32'd169, 1'b0);
        add_candidate(32'd997, 1'b0);
        add_candidate(32'd65521, 1'b0);
        add_candidate(32'd1052651, 1'b0);     // 1021 * 1031
        add_candidate(32'd1048573, 1'b0);
        add_candidate(32'd16777213, 1'b0);
        add_candidate(32'hFFFF_FFFF, 1'b0);
        add_candidate(32'hFFFF_FFFE, 1'b0);
        add_candidate(32'h8000_0000, 1'b0);
        add_candidate(32'h5555_5555, 1'b0);
        add_candidate(32'hAAAA_AAAA, 1'b0);

        // random: mostly small values so the run stays short; full-width
        // values are kept to multiples of two or three
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 8)
                x = $urandom_range(0, 4095);
            else if (kind < 12)
                x = $urandom_range(0, 65535);
            else if (kind < 17)
            begin
                x = $urandom;
                if ($urandom_range(0, 1) == 0)
                    x[0] = 1'b0;
                else
                    x = x - (x % 3);
            end
            else if (kind < 19)
                x = $urandom_range(0, 1 << 20);
            else
                x = factor_list[$urandom_range(0, 7)] * factor_list[$urandom_range(0, 7)];
            add_candidate(x, (i == 0) || ($urandom_range(0, 19) == 0));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the backlog and the pending verdicts to empty
        @(negedge clk);
        while (!(candidate_backlog.size() == 0 && !cand_valid &&
                 pending_verdicts.size() == 0) && idle_cycles < STALL_LIMIT)
            @(negedge clk);

        if (idle_cycles >= STALL_LIMIT)
            $display("Testbench completed WITH ERRORS");
        else
        begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (mismatches == 0 && pending_verdicts.size() == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ trial_division_prime_test.f @@
hdl/tdp_pkg.sv
hdl/tdp_div.sv
hdl/trial_division_prime_test.sv
tb/tb_trial_division_prime_test.sv
